FILE: sv/blf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blf_pkg: shared definitions for the bounded LIFO stack
// Opcodes, status codes, field widths and the response record.
// ---------------------------------------------------------------------------
package blf_pkg;

	// Field widths
	localparam int OP_W    = 3;
	localparam int DATA_W  = 32;
	localparam int ST_W    = 2;
	localparam int DEPTH_W = 7;

	// Default stack capacity
	localparam int STACK_DEPTH_DEF = 64;

	// Opcodes (6 and 7 are no-ops)
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_DUP   = 3'd3;
	localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// One response
	typedef struct packed {
		logic [DATA_W-1:0]  read_value;
		logic               read_valid;
		logic [ST_W-1:0]    status;
		logic               now_empty;
		logic [DEPTH_W-1:0] depth;
	} rsp_t;

endpackage

FILE: sv/blf_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blf_req_if: request channel of the LIFO stack
// valid/ready handshake carrying an opcode and a push word.
// ---------------------------------------------------------------------------
interface blf_req_if;
	logic                       valid;
	logic                       ready;
	logic [blf_pkg::OP_W-1:0]   opcode;
	logic [blf_pkg::DATA_W-1:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

FILE: sv/blf_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blf_rsp_if: response channel of the LIFO stack
// valid/ready handshake carrying read data, status and depth.
// ---------------------------------------------------------------------------
interface blf_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [blf_pkg::DATA_W-1:0]  read_value;
	logic                        read_valid;
	logic [blf_pkg::ST_W-1:0]    status;
	logic                        now_empty;
	logic [blf_pkg::DEPTH_W-1:0] depth;

	modport source (output valid, output read_value, output read_valid, output status,
		output now_empty, output depth, input ready);
	modport sink   (input valid, input read_value, input read_valid, input status,
		input now_empty, input depth, output ready);
endinterface

FILE: sv/blf_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blf_store: entry memory below the two cached top entries
// One write port, one registered read port with write-to-read bypass.
// ---------------------------------------------------------------------------
module blf_store #(
	parameter int STACK_DEPTH = blf_pkg::STACK_DEPTH_DEF,
	localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [blf_pkg::DATA_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [blf_pkg::DATA_W-1:0] rd_data
);

	logic [blf_pkg::DATA_W-1:0] mem_q [STACK_DEPTH];
	logic [blf_pkg::DATA_W-1:0] rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read; a same-cycle write to the read address wins
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: sv/blf_exec.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blf_exec: stack operation unit
// Holds the count and the top two entries in registers; deeper entries live
// in blf_store, whose read port always presents the third entry from the top.
// ---------------------------------------------------------------------------
module blf_exec #(
	parameter int STACK_DEPTH = blf_pkg::STACK_DEPTH_DEF,
	localparam int CW = $clog2(STACK_DEPTH + 1),
	localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [blf_pkg::OP_W-1:0]   opcode,
	input  logic [blf_pkg::DATA_W-1:0] push_value,
	output blf_pkg::rsp_t              result,
	output logic [CW-1:0]              count
);

	logic [CW-1:0]              count_q, count_n;
	logic [blf_pkg::DATA_W-1:0] top_q, top_n;
	logic [blf_pkg::DATA_W-1:0] next_q, next_n;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_addr;
	logic [blf_pkg::DATA_W-1:0] third;
	logic                       is_empty, is_full, has_two;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(STACK_DEPTH));
	assign has_two  = (count_q >= CW'(2));

	// Entry below next goes to memory slot count-2 on a push or dup
	assign wr_addr = AW'(count_q - CW'(2));
	// Keep the third entry of the upcoming state prefetched
	assign rd_addr = AW'(count_n - CW'(3));

	blf_store #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (next_q),
		.rd_addr (rd_addr),
		.rd_data (third)
	);

	// Operation decode and next state
	always_comb begin
		count_n           = count_q;
		top_n             = top_q;
		next_n            = next_q;
		wr_en             = 1'b0;
		result.read_value = '0;
		result.read_valid = 1'b0;
		result.status     = blf_pkg::ST_OK;
		if (fire) begin
			case (opcode)
				blf_pkg::OP_PUSH: begin
					if (is_full) begin
						result.status = blf_pkg::ST_FULL;
					end else begin
						wr_en   = has_two;
						top_n   = push_value;
						next_n  = top_q;
						count_n = count_q + CW'(1);
					end
				end
				blf_pkg::OP_POP: begin
					if (is_empty) begin
						result.status = blf_pkg::ST_EMPTY;
					end else begin
						result.read_value = top_q;
						result.read_valid = 1'b1;
						top_n   = next_q;
						next_n  = third;
						count_n = count_q - CW'(1);
					end
				end
				blf_pkg::OP_PEEK: begin
					if (is_empty) begin
						result.status = blf_pkg::ST_EMPTY;
					end else begin
						result.read_value = top_q;
						result.read_valid = 1'b1;
					end
				end
				blf_pkg::OP_DUP: begin
					if (is_empty) begin
						result.status = blf_pkg::ST_EMPTY;
					end else if (is_full) begin
						result.status = blf_pkg::ST_FULL;
					end else begin
						wr_en   = has_two;
						next_n  = top_q;
						count_n = count_q + CW'(1);
					end
				end
				blf_pkg::OP_SWAP: begin
					if (!has_two) begin
						result.status = blf_pkg::ST_EMPTY;
					end else begin
						top_n  = next_q;
						next_n = top_q;
					end
				end
				blf_pkg::OP_CLEAR: begin
					count_n = '0;
				end
				default: begin
				end
			endcase
		end
		result.now_empty = (count_n == '0);
		result.depth     = blf_pkg::DEPTH_W'(count_n);
	end

	// Count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

	// Cached top entries
	always_ff @(posedge clk) begin
		top_q  <= top_n;
		next_q <= next_n;
	end

	assign count = count_q;

endmodule

FILE: sv/bounded_lifo_stack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_lifo_stack: bounded LIFO stack of 32-bit words
// Push, pop, peek, dup, swap and clear; one response per request.
// ---------------------------------------------------------------------------
// Usage:
//   req carries opcode and push_value; rsp returns read_value, read_valid,
//   status, now_empty and depth after the operation. Every request gives
//   exactly one response, in order.
//   An accepted request is captured in the input register, then the operation
//   result is registered into the response register.
//   Throughput: one request per cycle unless the response stalls. The top
//   two entries and the count sit in flops and the memory read port keeps
//   the third entry fetched, so every operation finishes in a single pass.
//   Reset: arst_n empties the stack and drops both pipeline valids; the
//   entry memory is not cleared and needs no sweep, entries are read only
//   after being written.
//   Stall: when rsp.ready is low the response holds; the input register
//   still takes one more request, then req.ready drops until rsp drains.
// ---------------------------------------------------------------------------
module bounded_lifo_stack #(
	parameter int STACK_DEPTH = blf_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	blf_req_if.sink    req,
	blf_rsp_if.source  rsp
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic                       valid_s1;
	logic [blf_pkg::OP_W-1:0]   opcode_s1;
	logic [blf_pkg::DATA_W-1:0] push_value_s1;
	logic                       rsp_valid_q;
	blf_pkg::rsp_t              rsp_q;
	blf_pkg::rsp_t              result;
	logic [CW-1:0]              count;
	logic                       out_free;
	logic                       advance;

	// Handshake control
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1     <= req.opcode;
			push_value_s1 <= req.push_value;
		end
	end

	// Operation unit
	blf_exec #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.opcode     (opcode_s1),
		.push_value (push_value_s1),
		.result     (result),
		.count      (count)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_q.read_value;
	assign rsp.read_valid = rsp_q.read_valid;
	assign rsp.status     = rsp_q.status;
	assign rsp.now_empty  = rsp_q.now_empty;
	assign rsp.depth      = rsp_q.depth;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(STACK_DEPTH))
		else $error("stack count above capacity");

	a_advance_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("processed request produced no response");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.read_valid) |-> (rsp_q.status == blf_pkg::ST_OK))
		else $error("read data flagged with error status");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (rsp_q.now_empty == (count == '0)))
		else $error("empty flag disagrees with count");

endmodule
